// ===== rtl/core/sit_pkg.sv =====
// Package for the segment intersection test unit.
// Holds the coordinate width, the derived arithmetic types and the sign struct.
// No dependencies; every other file but sit_out_if imports it.
package sit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;

    // Sign of one oriented area: both flags low means the area is zero.
    typedef struct packed {
        logic pos;
        logic neg;
    } sign_t;

    // Exact difference b - a, one bit wider than a coordinate.
    function automatic diff_t coord_diff(input coord_t a, input coord_t b);
        return diff_t'(b) - diff_t'(a);
    endfunction

endpackage

// ===== rtl/core/sit_in_if.sv =====
// Request channel carrying the endpoints of two segments.
// Depends on sit_pkg for the coordinate type.
interface sit_in_if
    import sit_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );

    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

// ===== rtl/core/sit_out_if.sv =====
// Result channel carrying the one-bit intersection answer.
// No dependencies.
interface sit_out_if;
    logic valid;
    logic ready;
    logic crosses;

    modport source (
        output valid, crosses,
        input  ready
    );

    modport sink (
        input  valid, crosses,
        output ready
    );
endinterface

// ===== rtl/core/sit_area.sv =====
// One oriented area unit: registers the two cross-product terms and
// compares them to give the sign of the area. Depends on sit_pkg.
module sit_area
    import sit_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  diff_t bx_ax,
    input  diff_t cy_ay,
    input  diff_t by_ay,
    input  diff_t cx_ax,
    output sign_t sign
);

    prod_t lhs_reg;
    prod_t rhs_reg;
    prod_t lhs_next;
    prod_t rhs_next;

    assign lhs_next = bx_ax * cy_ay;
    assign rhs_next = by_ay * cx_ax;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
        end
    end

    assign sign.pos = lhs_reg > rhs_reg;
    assign sign.neg = lhs_reg < rhs_reg;

endmodule

// ===== rtl/core/segment_intersection_test_unit.sv =====
// Top level of the segment intersection test unit: three-stage pipeline.
// Depends on sit_pkg, sit_in_if, sit_out_if and sit_area.
//
//   Channel   Direction   Carries
//   segs      in          eight coordinates, two segments
//   result    out         crosses, one bit
//
// One request may enter in every cycle unless result stalls; its answer is
// registered as differences and extents, then products, then the sign compare
// in the output register. Each stage holds its request while the stage behind
// is full and stalled, so a stall on result loses and repeats nothing, and an
// empty stage still lets a new request in. Reset clears the valid bits only.
module segment_intersection_test_unit
    import sit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sit_in_if.sink    segs,
    sit_out_if.source result
);

    // Stage 1: differences and segment extents.
    logic   v1_reg;
    logic   v1_next;
    diff_t  dpx_reg, dpy_reg;      // second point of first segment minus first
    diff_t  dqx_reg, dqy_reg;
    diff_t  q1p1x_reg, q1p1y_reg;
    diff_t  q2p1x_reg, q2p1y_reg;
    diff_t  p1q1x_reg, p1q1y_reg;
    diff_t  p2q1x_reg, p2q1y_reg;
    coord_t plox_reg, phix_reg, ploy_reg, phiy_reg;
    coord_t qlox_reg, qhix_reg, qloy_reg, qhiy_reg;

    // Stage 2: products live in the area units; extents reduced to one bit.
    logic   v2_reg;
    logic   v2_next;
    logic   ext_ok_reg;
    logic   ext_ok_next;

    // Stage 3: output register.
    logic   v3_reg;
    logic   v3_next;
    logic   crosses_reg;
    logic   crosses_next;

    logic   ready1, ready2, ready3;
    logic   load2;
    sign_t  s1, s2, s3, s4;

    coord_t lox_max, hix_min, loy_max, hiy_min;

    assign ready3 = !v3_reg || result.ready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign load2  = ready2 && v1_reg;

    assign segs.ready = ready1;

    assign v1_next = ready1 ? segs.valid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;
    assign v3_next = ready3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && segs.valid)
        begin
            dpx_reg   <= coord_diff(segs.first_start_x, segs.first_end_x);
            dpy_reg   <= coord_diff(segs.first_start_y, segs.first_end_y);
            dqx_reg   <= coord_diff(segs.second_start_x, segs.second_end_x);
            dqy_reg   <= coord_diff(segs.second_start_y, segs.second_end_y);
            q1p1x_reg <= coord_diff(segs.first_start_x, segs.second_start_x);
            q1p1y_reg <= coord_diff(segs.first_start_y, segs.second_start_y);
            q2p1x_reg <= coord_diff(segs.first_start_x, segs.second_end_x);
            q2p1y_reg <= coord_diff(segs.first_start_y, segs.second_end_y);
            p1q1x_reg <= coord_diff(segs.second_start_x, segs.first_start_x);
            p1q1y_reg <= coord_diff(segs.second_start_y, segs.first_start_y);
            p2q1x_reg <= coord_diff(segs.second_start_x, segs.first_end_x);
            p2q1y_reg <= coord_diff(segs.second_start_y, segs.first_end_y);

            if (segs.first_start_x < segs.first_end_x)
            begin
                plox_reg <= segs.first_start_x;
                phix_reg <= segs.first_end_x;
            end
            else
            begin
                plox_reg <= segs.first_end_x;
                phix_reg <= segs.first_start_x;
            end
            if (segs.first_start_y < segs.first_end_y)
            begin
                ploy_reg <= segs.first_start_y;
                phiy_reg <= segs.first_end_y;
            end
            else
            begin
                ploy_reg <= segs.first_end_y;
                phiy_reg <= segs.first_start_y;
            end
            if (segs.second_start_x < segs.second_end_x)
            begin
                qlox_reg <= segs.second_start_x;
                qhix_reg <= segs.second_end_x;
            end
            else
            begin
                qlox_reg <= segs.second_end_x;
                qhix_reg <= segs.second_start_x;
            end
            if (segs.second_start_y < segs.second_end_y)
            begin
                qloy_reg <= segs.second_start_y;
                qhiy_reg <= segs.second_end_y;
            end
            else
            begin
                qloy_reg <= segs.second_end_y;
                qhiy_reg <= segs.second_start_y;
            end
        end
    end

    // The extents meet when the larger of the lows does not pass the smaller
    // of the highs, on both axes.
    assign lox_max = (plox_reg > qlox_reg) ? plox_reg : qlox_reg;
    assign hix_min = (phix_reg < qhix_reg) ? phix_reg : qhix_reg;
    assign loy_max = (ploy_reg > qloy_reg) ? ploy_reg : qloy_reg;
    assign hiy_min = (phiy_reg < qhiy_reg) ? phiy_reg : qhiy_reg;

    assign ext_ok_next = (lox_max <= hix_min) && (loy_max <= hiy_min);

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            ext_ok_reg <= ext_ok_next;
        end
    end

    // Areas of the second segment's endpoints against the first segment.
    sit_area u_area_q1 (
        .clk   (clk),
        .load  (load2),
        .bx_ax (dpx_reg),
        .cy_ay (q1p1y_reg),
        .by_ay (dpy_reg),
        .cx_ax (q1p1x_reg),
        .sign  (s1)
    );

    sit_area u_area_q2 (
        .clk   (clk),
        .load  (load2),
        .bx_ax (dpx_reg),
        .cy_ay (q2p1y_reg),
        .by_ay (dpy_reg),
        .cx_ax (q2p1x_reg),
        .sign  (s2)
    );

    // Areas of the first segment's endpoints against the second segment.
    sit_area u_area_p1 (
        .clk   (clk),
        .load  (load2),
        .bx_ax (dqx_reg),
        .cy_ay (p1q1y_reg),
        .by_ay (dqy_reg),
        .cx_ax (p1q1x_reg),
        .sign  (s3)
    );

    sit_area u_area_p2 (
        .clk   (clk),
        .load  (load2),
        .bx_ax (dqx_reg),
        .cy_ay (p2q1y_reg),
        .by_ay (dqy_reg),
        .cx_ax (p2q1x_reg),
        .sign  (s4)
    );

    // A pair of areas fails only when both are strictly on the same side.
    assign crosses_next = ext_ok_reg
                       && !((s1.pos && s2.pos) || (s1.neg && s2.neg))
                       && !((s3.pos && s4.pos) || (s3.neg && s4.neg));

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            crosses_reg <= crosses_next;
        end
    end

    assign result.valid   = v3_reg;
    assign result.crosses = crosses_reg;

    // A full pipeline with a stalled output must refuse new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !result.ready) |-> !segs.ready)
        else $error("request accepted into a full, stalled pipeline");

    // An empty first stage always takes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> segs.ready)
        else $error("first stage empty but request refused");

    // An accepted request occupies the first stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (segs.valid && segs.ready) |=> v1_reg)
        else $error("accepted request lost from the first stage");

    // A request in the middle stage stays there while the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ready3) |=> v2_reg)
        else $error("middle stage dropped a request during a stall");

endmodule

// ===== verif/segment_intersection_test_unit_tb.sv =====
// Testbench for segment_intersection_test_unit: drives segment pairs, predicts most
// crossing answers independently and checks them against every result it returns.
// Depends on sit_pkg, sit_in_if, sit_out_if and the block itself.
module segment_intersection_test_unit_tb
    import sit_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED  = 21;
    localparam int RANDOM_ITEMS  = 450;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int EXTREMES [7]  = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    typedef struct packed {
        coord_t first_start_x;
        coord_t first_start_y;
        coord_t first_end_x;
        coord_t first_end_y;
        coord_t second_start_x;
        coord_t second_start_y;
        coord_t second_end_x;
        coord_t second_end_y;
    } seg_pair_t;

    typedef enum logic [1:0] {
        ANS_PREDICT,
        ANS_APART,
        ANS_MEET
    } answer_e;

    typedef struct packed {
        seg_pair_t seg;
        answer_e   answer;
    } seg_row_t;

    typedef enum int {
        MIX_WILD,
        MIX_TINY,
        MIX_SHARED,
        MIX_COLLINEAR,
        MIX_TEE,
        MIX_POINT,
        MIX_CROSS,
        MIX_EXTREME,
        MIX_PARALLEL
    } mix_e;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;
    logic sink_ready = 1'b0;

    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   burst_left;
    logic pending_crossings [$];

    sit_in_if  segs_if ();
    sit_out_if result_if ();

    assign result_if.ready = sink_ready;

    segment_intersection_test_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .segs   (segs_if.sink),
        .result (result_if.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Fields in the order fsx, fsy, fex, fey, ssx, ssy, sex, sey.
    seg_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{-32768, -32768,  32767,  32767, -32768,  32767,  32767, -32768}, ANS_MEET},
        '{'{-32768, -32768,  32767, -32768, -32768,  32767,  32767,  32767}, ANS_APART},
        '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, ANS_MEET},
        '{'{ 32767,  32767,  32767,  32767,  32767,  32767,  32767,  32767}, ANS_MEET},
        '{'{-32768, -32768, -32768, -32768,  32767,  32767,  32767,  32767}, ANS_APART},
        '{'{     0,      0,      0,      0,      0,      0,      0,      0}, ANS_MEET},
        '{'{     0,      0,     10,      0,      5,      0,     20,      0}, ANS_PREDICT},
        '{'{     0,      0,     10,      0,     11,      0,     20,      0}, ANS_PREDICT},
        '{'{     0,      0,     10,      0,     10,      0,     20,      0}, ANS_PREDICT},
        '{'{     0,      0,     10,      0,      5,      0,      5,     10}, ANS_PREDICT},
        '{'{     0,      0,     10,      0,      5,      1,      5,     10}, ANS_PREDICT},
        '{'{     0,      0,     10,     10,      5,      5,      5,      5}, ANS_PREDICT},
        '{'{     0,      0,     10,     10,      5,      6,      5,      6}, ANS_PREDICT},
        '{'{     0,      0,     10,      0,      5,      1,     15,      1}, ANS_PREDICT},
        '{'{-32768, -32768,      0,      0,     -1,     -1,  32767,  32767}, ANS_PREDICT},
        '{'{    -5,     -5,      5,      5,     -5,      5,      5,     -5}, ANS_PREDICT},
        '{'{ 32767, -32768,      0,      0,      0,      0, -32768,  32767}, ANS_PREDICT},
        '{'{     5,      5,     -5,     -5,      5,     -5,     -5,      5}, ANS_PREDICT},
        '{'{     7, -32768,      7,     -1,      7,      0,      7,  32767}, ANS_PREDICT},
        '{'{ 21845, -21846, -21846,  21845, -21846, -21846,  21845,  21845}, ANS_PREDICT},
        '{'{    -1,      1,      1,     -1,     -1,     -1,      1,      1}, ANS_PREDICT}
    };

    // Sign of the cross product (b - a) x (c - a).
    function automatic int area_sense(input longint ax, input longint ay, input longint bx,
                                      input longint by, input longint cx, input longint cy);
        longint lhs;
        longint rhs;
        lhs = (bx - ax) * (cy - ay);
        rhs = (by - ay) * (cx - ax);
        if (lhs > rhs)
            return 1;
        else if (lhs < rhs)
            return -1;
        return 0;
    endfunction

    function automatic bit spans_meet(input longint a0, input longint a1,
                                      input longint b0, input longint b1);
        longint lo_a;
        longint hi_a;
        longint lo_b;
        longint hi_b;
        lo_a = (a0 < a1) ? a0 : a1;
        hi_a = (a0 < a1) ? a1 : a0;
        lo_b = (b0 < b1) ? b0 : b1;
        hi_b = (b0 < b1) ? b1 : b0;
        return ((lo_a > lo_b) ? lo_a : lo_b) <= ((hi_a < hi_b) ? hi_a : hi_b);
    endfunction

    function automatic logic predict_crossing(input seg_pair_t s);
        longint p1x;
        longint p1y;
        longint p2x;
        longint p2y;
        longint q1x;
        longint q1y;
        longint q2x;
        longint q2y;
        bit     straddle_first;
        bit     straddle_second;
        p1x = longint'(s.first_start_x);
        p1y = longint'(s.first_start_y);
        p2x = longint'(s.first_end_x);
        p2y = longint'(s.first_end_y);
        q1x = longint'(s.second_start_x);
        q1y = longint'(s.second_start_y);
        q2x = longint'(s.second_end_x);
        q2y = longint'(s.second_end_y);
        straddle_first  = area_sense(p1x, p1y, p2x, p2y, q1x, q1y)
                        * area_sense(p1x, p1y, p2x, p2y, q2x, q2y) <= 0;
        straddle_second = area_sense(q1x, q1y, q2x, q2y, p1x, p1y)
                        * area_sense(q1x, q1y, q2x, q2y, p2x, p2y) <= 0;
        return spans_meet(p1x, p2x, q1x, q2x) && spans_meet(p1y, p2y, q1y, q2y)
            && straddle_first && straddle_second;
    endfunction

    function automatic int signed_pick(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Mostly well-shaped pairs (touching, collinear, spread around a common point, near
    // misses) kept well inside the coordinate range, with full-range noise mixed in.
    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        mix_e      mix;
        int        bx;
        int        by;
        int        dx;
        int        dy;
        int        ex;
        int        ey;
        int        k0;
        int        k1;
        int        k2;
        int        k3;
        int        j;
        s   = seg_pair_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        mix = mix_e'($urandom_range(0, 8));
        bx  = signed_pick(20000);
        by  = signed_pick(20000);
        dx  = signed_pick(60);
        dy  = signed_pick(60);
        ex  = signed_pick(60);
        ey  = signed_pick(60);
        k0  = signed_pick(40);
        k1  = signed_pick(40);
        k2  = signed_pick(40);
        k3  = signed_pick(40);
        case (mix)
            MIX_TINY:
            begin
                for (int i = 0; i < 8; i++)
                    s[i*COORD_WIDTH +: COORD_WIDTH] = coord_t'(signed_pick(8));
            end
            MIX_SHARED:
            begin
                s.first_start_x  = coord_t'(bx);
                s.first_start_y  = coord_t'(by);
                s.first_end_x    = coord_t'(bx + k0 * dx);
                s.first_end_y    = coord_t'(by + k0 * dy);
                s.second_start_x = s.first_end_x;
                s.second_start_y = s.first_end_y;
                s.second_end_x   = coord_t'(bx + k1 * ex);
                s.second_end_y   = coord_t'(by + k1 * ey);
            end
            MIX_COLLINEAR:
            begin
                s.first_start_x  = coord_t'(bx + k0 * dx);
                s.first_start_y  = coord_t'(by + k0 * dy);
                s.first_end_x    = coord_t'(bx + k1 * dx);
                s.first_end_y    = coord_t'(by + k1 * dy);
                s.second_start_x = coord_t'(bx + k2 * dx);
                s.second_start_y = coord_t'(by + k2 * dy);
                s.second_end_x   = coord_t'(bx + k3 * dx);
                s.second_end_y   = coord_t'(by + k3 * dy);
            end
            MIX_TEE:
            begin
                j = (k0 >= 0) ? int'($urandom_range(0, k0)) : -int'($urandom_range(0, -k0));
                s.first_start_x  = coord_t'(bx);
                s.first_start_y  = coord_t'(by);
                s.first_end_x    = coord_t'(bx + k0 * dx);
                s.first_end_y    = coord_t'(by + k0 * dy);
                s.second_start_x = coord_t'(bx + j * dx);
                s.second_start_y = coord_t'(by + j * dy);
                s.second_end_x   = coord_t'(bx + j * dx + k1 * ex);
                s.second_end_y   = coord_t'(by + j * dy + k1 * ey);
            end
            MIX_POINT:
            begin
                s.first_start_x  = coord_t'(bx + k0 * dx);
                s.first_start_y  = coord_t'(by + k0 * dy);
                s.first_end_x    = s.first_start_x;
                s.first_end_y    = s.first_start_y;
                s.second_start_x = coord_t'(bx);
                s.second_start_y = coord_t'(by);
                s.second_end_x   = coord_t'(bx + k1 * dx);
                s.second_end_y   = coord_t'(by + k1 * dy);
                if ($urandom_range(0, 2) == 0)
                begin
                    s.second_end_x = s.second_start_x;
                    s.second_end_y = s.second_start_y;
                end
            end
            MIX_CROSS:
            begin
                s.first_start_x  = coord_t'(bx - int'($urandom_range(1, 40)) * dx);
                s.first_start_y  = coord_t'(by - int'($urandom_range(1, 40)) * dy);
                s.first_end_x    = coord_t'(bx + int'($urandom_range(1, 40)) * dx);
                s.first_end_y    = coord_t'(by + int'($urandom_range(1, 40)) * dy);
                s.second_start_x = coord_t'(bx - int'($urandom_range(1, 40)) * ex);
                s.second_start_y = coord_t'(by - int'($urandom_range(1, 40)) * ey);
                s.second_end_x   = coord_t'(bx + int'($urandom_range(1, 40)) * ex);
                s.second_end_y   = coord_t'(by + int'($urandom_range(1, 40)) * ey);
            end
            MIX_EXTREME:
            begin
                for (int i = 0; i < 8; i++)
                    s[i*COORD_WIDTH +: COORD_WIDTH] = coord_t'(EXTREMES[$urandom_range(0, 6)]);
            end
            MIX_PARALLEL:
            begin
                s.first_start_x  = coord_t'(bx);
                s.first_start_y  = coord_t'(by);
                s.first_end_x    = coord_t'(bx + k0 * dx);
                s.first_end_y    = coord_t'(by + k0 * dy);
                bx               = bx + signed_pick(2);
                by               = by + signed_pick(2);
                s.second_start_x = coord_t'(bx + k2 * dx);
                s.second_start_y = coord_t'(by + k2 * dy);
                s.second_end_x   = coord_t'(bx + k3 * dx);
                s.second_end_y   = coord_t'(by + k3 * dy);
            end
            default:
            begin
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            s = seg_pair_t'({s[4*COORD_WIDTH-1:0], s[8*COORD_WIDTH-1:4*COORD_WIDTH]});
        return s;
    endfunction

    function automatic int next_burst();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(30, 80);
        return $urandom_range(1, 8);
    endfunction

    // Holds a request on the channel until it is taken; idles between bursts.
    task automatic send_pair(input seg_pair_t s, input logic want);
        segs_if.valid          <= 1'b1;
        segs_if.first_start_x  <= s.first_start_x;
        segs_if.first_start_y  <= s.first_start_y;
        segs_if.first_end_x    <= s.first_end_x;
        segs_if.first_end_y    <= s.first_end_y;
        segs_if.second_start_x <= s.second_start_x;
        segs_if.second_start_y <= s.second_start_y;
        segs_if.second_end_x   <= s.second_end_x;
        segs_if.second_end_y   <= s.second_end_y;
        @(posedge clk);
        while (segs_if.ready !== 1'b1)
            @(posedge clk);
        pending_crossings.push_back(want);
        burst_left--;
        if (burst_left <= 0)
        begin
            segs_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = next_burst();
        end
    endtask

    task automatic wait_all_answered();
        segs_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_crossings.size() != 0)
            @(posedge clk);
    endtask

    // The receiver switches at random between stall patterns.
    rx_mode_e rx_mode = RX_OPEN;
    int       rx_mode_left = 0;

    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_e'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(10, 60);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN:     sink_ready <= 1'b1;
            RX_COIN:     sink_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:     sink_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: sink_ready <= (cycle_count % 5 != 2);
            default:     sink_ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (pending_crossings.size() == 0)
            begin
                $error("crosses: no request outstanding, actual %0b", result_if.crosses);
                mismatch_count++;
            end
            else if (result_if.crosses !== pending_crossings[0])
            begin
                $error("crosses: expected %0b, actual %0b", pending_crossings[0],
                       result_if.crosses);
                mismatch_count++;
                void'(pending_crossings.pop_front());
            end
            else
            begin
                void'(pending_crossings.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        seg_pair_t s;
        logic      want;
        rst_n                  = 1'b0;
        segs_if.valid          = 1'b0;
        segs_if.first_start_x  = '0;
        segs_if.first_start_y  = '0;
        segs_if.first_end_x    = '0;
        segs_if.first_end_y    = '0;
        segs_if.second_start_x = '0;
        segs_if.second_start_y = '0;
        segs_if.second_end_x   = '0;
        segs_if.second_end_y   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = next_burst();

        foreach (directed_rows[i])
        begin
            s = directed_rows[i].seg;
            if (directed_rows[i].answer == ANS_PREDICT)
                want = predict_crossing(s);
            else
                want = (directed_rows[i].answer == ANS_MEET);
            send_pair(s, want);
        end

        // Let the pipeline run dry once before the random requests start.
        wait_all_answered();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            s = random_pair();
            send_pair(s, predict_crossing(s));
            if ($urandom_range(0, 99) == 0)
                wait_all_answered();
        end

        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
